FILE: rtl/fbpa_pkg.sv
// Fixed block pool allocator: shared types, pool shape table and helpers.
// No dependencies; imported by the pool and result stages, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  localparam int TABLE_LEN = 7;
  localparam int BYTES_W   = 9;
  localparam int SHIFT_W   = 4;
  localparam int DIV_W     = 16;

  localparam logic [BYTES_W-1:0] SHAPE_BYTES [TABLE_LEN] =
    '{9'd8, 9'd16, 9'd32, 9'd48, 9'd64, 9'd128, 9'd256};
  localparam int SHAPE_BLOCKS [TABLE_LEN] = '{40, 20, 20, 20, 20, 10, 5};
  localparam logic [SHIFT_W-1:0] SHAPE_SHIFT [TABLE_LEN] =
    '{4'd3, 4'd4, 4'd5, 4'd4, 4'd6, 4'd7, 4'd8};
  localparam logic SHAPE_BY3 [TABLE_LEN] =
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEM     = 2'd1,
    ST_BELOW_HEAP = 2'd2,
    ST_REJECTED   = 2'd3
  } status_e;

  // control word handed from the pool stage to the result stage
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    alloc_ok;
    logic    use_ram;
  } fbpa_stage_t;

  function automatic int shape_sel(input int p);
    return (p < TABLE_LEN) ? p : TABLE_LEN - 1;
  endfunction

  function automatic logic [BYTES_W-1:0] pool_bytes(input int p);
    return SHAPE_BYTES[shape_sel(p)];
  endfunction

  function automatic logic [SHIFT_W-1:0] pool_shift(input int p);
    return SHAPE_SHIFT[shape_sel(p)];
  endfunction

  function automatic logic pool_by3(input int p);
    return SHAPE_BY3[shape_sel(p)];
  endfunction

  function automatic int pool_blocks(input int p, input int max_blocks);
    int n;
    n = (p < TABLE_LEN) ? SHAPE_BLOCKS[p] : 0;
    return (n > max_blocks) ? max_blocks : n;
  endfunction

  // x / (2^shift * (by3 ? 3 : 1)), exact for any 16-bit x
  function automatic logic [DIV_W-1:0] div_by_shape(input logic [DIV_W-1:0] x,
                                                    input logic [SHIFT_W-1:0] shift,
                                                    input logic by3);
    logic [DIV_W-1:0]   y;
    logic [2*DIV_W-1:0] prod;
    y    = x >> shift;
    prod = {{DIV_W{1'b0}}, y} * 32'd43691;
    return by3 ? {1'b0, prod[2*DIV_W-1:17]} : y;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fbpa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/fbpa_apb_regs.sv
// APB register file: heap_base at 0x0, heap_end at 0x4.
// Depends on nothing; pready is tied high.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_apb_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] heap_base_o,
  output logic      [31:0] heap_end_o
);

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_END  = 1'b1;

  logic [31:0] heap_base_q;
  logic [31:0] heap_end_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      heap_end_q  <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HEAP_BASE: heap_base_q <= pwdata;
        REG_HEAP_END:  heap_end_q  <= pwdata;
        default:       heap_base_q <= heap_base_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEAP_BASE: prdata = heap_base_q;
      REG_HEAP_END:  prdata = heap_end_q;
      default:       prdata = '0;
    endcase
  end

  assign heap_base_o = heap_base_q;
  assign heap_end_o  = heap_end_q;

endmodule

`default_nettype wire

FILE: rtl/fbpa_pool_state.sv
// Pool stage: input register, pool bookkeeping, layout sequencer, stack port.
// Depends on fbpa_pkg; drives the stack RAM and the result stage.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_pool_state import fbpa_pkg::*; #(
  parameter int POOL_COUNT = 7,
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32,
  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int RAW = (POOL_COUNT * MAX_BLOCKS > 1) ? $clog2(POOL_COUNT * MAX_BLOCKS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [15:0]          req_size_i,
  input  wire logic [ADDR_BITS-1:0] req_addr_i,
  input  wire logic [ADDR_BITS-1:0] heap_base_i,
  input  wire logic [ADDR_BITS-1:0] heap_end_i,
  input  wire logic                 s2_ready_i,
  output fbpa_stage_t               stage_o,
  output logic      [2:0]           pool_o,
  output logic      [6:0]           cnt_o,
  output logic      [ADDR_BITS-1:0] start_o,
  output logic      [BYTES_W-1:0]   bytes_o,
  output logic      [IW-1:0]        idx_o,
  output logic                      ram_we_o,
  output logic      [RAW-1:0]       ram_waddr_o,
  output logic      [IW-1:0]        ram_wdata_o,
  output logic                      ram_re_o,
  output logic      [RAW-1:0]       ram_raddr_o
);

  localparam int AW   = ADDR_BITS;
  localparam int PIW  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int SPW  = CW + BYTES_W;
  localparam int CMPW = (AW > SPW) ? AW : SPW;

  // per-pool shape constants
  logic [BYTES_W-1:0] bytes_c [POOL_COUNT];
  logic [SHIFT_W-1:0] shift_c [POOL_COUNT];
  logic               by3_c   [POOL_COUNT];
  logic [CW-1:0]      nblk_c  [POOL_COUNT];
  logic [SPW-1:0]     full_c  [POOL_COUNT];

  for (genvar g = 0; g < POOL_COUNT; g++) begin : g_shape
    assign bytes_c[g] = pool_bytes(g);
    assign shift_c[g] = pool_shift(g);
    assign by3_c[g]   = pool_by3(g);
    assign nblk_c[g]  = CW'(pool_blocks(g, MAX_BLOCKS));
    assign full_c[g]  = SPW'(pool_blocks(g, MAX_BLOCKS)) * SPW'(pool_bytes(g));
  end

  // pool state; low_q is the lowest stack fill since the last layout, so
  // stack entries below it still hold their own index
  logic [AW-1:0]  start_q [POOL_COUNT];
  logic [CW-1:0]  laid_q  [POOL_COUNT];
  logic [CW-1:0]  fc_q    [POOL_COUNT];
  logic [CW-1:0]  low_q   [POOL_COUNT];
  logic [SPW-1:0] span_q  [POOL_COUNT];

  logic           s1_valid_q;
  logic [1:0]     s1_type_q;
  logic [15:0]    s1_size_q;
  logic [AW-1:0]  s1_addr_q;

  logic [PIW-1:0] init_p_q;
  logic [AW-1:0]  ptr_q;

  logic           is_init;
  logic           init_last;
  logic           init_step;
  logic           s1_fire;

  logic [AW-1:0]  cur_ptr;
  logic [AW-1:0]  rem;
  logic           rem_ok;
  logic [CW-1:0]  laid_new;
  logic [SPW-1:0] span_new;

  logic           alloc_hit;
  logic [PIW-1:0] alloc_p;
  logic           free_hit;
  logic [PIW-1:0] free_p;

  logic [CW-1:0]  top;
  logic           top_lt_low;
  logic [AW-1:0]  off;
  logic           off_ok;
  logic           free_ok;
  logic           alloc_ok;
  logic [IW-1:0]  free_idx;

  assign is_init   = (s1_type_q == REQ_INIT);
  assign init_last = (init_p_q == PIW'(POOL_COUNT - 1));
  assign init_step = s1_valid_q & is_init & (~init_last | s2_ready_i);
  assign s1_fire   = s1_valid_q & s2_ready_i & (~is_init | init_last);
  assign in_ready_o = ~s1_valid_q | s1_fire;

  // layout of one pool per cycle; the last pool waits until the result stage is ready
  always_comb begin
    cur_ptr = (init_p_q == '0) ? heap_base_i : ptr_q;
    rem_ok  = heap_end_i > cur_ptr;
    rem     = heap_end_i - cur_ptr - 1'b1;
    if (!rem_ok) begin
      laid_new = '0;
    end else if (CMPW'(rem) >= CMPW'(full_c[init_p_q])) begin
      laid_new = nblk_c[init_p_q];
    end else begin
      laid_new = CW'(div_by_shape(rem[DIV_W-1:0], shift_c[init_p_q], by3_c[init_p_q]));
    end
    span_new = SPW'(laid_new) * SPW'(bytes_c[init_p_q]);
  end

  always_comb begin
    alloc_hit = 1'b0;
    alloc_p   = '0;
    for (int p = POOL_COUNT - 1; p >= 0; p--) begin
      if ((16'(bytes_c[p]) >= s1_size_q) && (fc_q[p] != '0)) begin
        alloc_hit = 1'b1;
        alloc_p   = PIW'(p);
      end
    end
  end

  always_comb begin
    free_hit = 1'b0;
    free_p   = '0;
    for (int p = 0; p < POOL_COUNT; p++) begin
      if (s1_addr_q >= start_q[p]) begin
        free_hit = 1'b1;
        free_p   = PIW'(p);
      end
    end
  end

  assign top        = fc_q[alloc_p] - 1'b1;
  assign top_lt_low = top < low_q[alloc_p];
  assign off        = s1_addr_q - start_q[free_p];
  assign off_ok     = CMPW'(off) < CMPW'(span_q[free_p]);
  assign free_idx   = IW'(div_by_shape(off[DIV_W-1:0], shift_c[free_p], by3_c[free_p]));
  assign free_ok    = (s1_type_q == REQ_FREE) & free_hit & off_ok &
                      (fc_q[free_p] < laid_q[free_p]);
  assign alloc_ok   = (s1_type_q == REQ_ALLOC) & alloc_hit;

  always_comb begin
    stage_o.valid    = s1_fire;
    stage_o.status   = ST_OK;
    stage_o.alloc_ok = 1'b0;
    stage_o.use_ram  = 1'b0;
    pool_o           = '0;
    cnt_o            = '0;
    start_o          = start_q[alloc_p];
    bytes_o          = bytes_c[alloc_p];
    idx_o            = top[IW-1:0];
    case (s1_type_q)
      REQ_ALLOC: begin
        if (alloc_hit) begin
          stage_o.alloc_ok = 1'b1;
          stage_o.use_ram  = ~top_lt_low;
          pool_o           = 3'(alloc_p);
          cnt_o            = 7'(top);
        end else begin
          stage_o.status = ST_NO_MEM;
        end
      end
      REQ_FREE: begin
        if (!free_hit) begin
          stage_o.status = ST_BELOW_HEAP;
        end else begin
          pool_o = 3'(free_p);
          if (free_ok) begin
            cnt_o = 7'(fc_q[free_p] + 1'b1);
          end else begin
            stage_o.status = ST_REJECTED;
            cnt_o          = 7'(fc_q[free_p]);
          end
        end
      end
      default: begin
        stage_o.status = ST_OK;
      end
    endcase
  end

  assign ram_re_o    = s1_fire & alloc_ok & ~top_lt_low;
  assign ram_raddr_o = RAW'(alloc_p) * RAW'(MAX_BLOCKS) + RAW'(top[IW-1:0]);
  assign ram_we_o    = s1_fire & free_ok;
  assign ram_waddr_o = RAW'(free_p) * RAW'(MAX_BLOCKS) + RAW'(fc_q[free_p][IW-1:0]);
  assign ram_wdata_o = free_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      init_p_q   <= '0;
      for (int p = 0; p < POOL_COUNT; p++) begin
        start_q[p] <= '0;
        laid_q[p]  <= '0;
        fc_q[p]    <= '0;
        low_q[p]   <= '0;
        span_q[p]  <= '0;
      end
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (init_step) begin
        start_q[init_p_q] <= cur_ptr;
        laid_q[init_p_q]  <= laid_new;
        fc_q[init_p_q]    <= laid_new;
        low_q[init_p_q]   <= laid_new;
        span_q[init_p_q]  <= span_new;
        init_p_q          <= init_last ? '0 : init_p_q + 1'b1;
      end
      if (s1_fire && alloc_ok) begin
        fc_q[alloc_p] <= top;
        if (top_lt_low) begin
          low_q[alloc_p] <= top;
        end
      end
      if (s1_fire && free_ok) begin
        fc_q[free_p] <= fc_q[free_p] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_type_q <= req_type_i;
      s1_size_q <= req_size_i;
      s1_addr_q <= req_addr_i;
    end
    if (init_step) begin
      ptr_q <= cur_ptr + AW'(span_new);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fbpa_result.sv
// Result stage: block address from pool start and stack index, output register.
// Depends on fbpa_pkg; fed by fbpa_pool_state and the stack RAM read port.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_result import fbpa_pkg::*; #(
  parameter int ADDR_BITS = 32,
  parameter int IDX_BITS  = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fbpa_stage_t          stage_i,
  input  wire logic [2:0]           pool_i,
  input  wire logic [6:0]           cnt_i,
  input  wire logic [ADDR_BITS-1:0] start_i,
  input  wire logic [BYTES_W-1:0]   bytes_i,
  input  wire logic [IDX_BITS-1:0]  idx_i,
  input  wire logic [IDX_BITS-1:0]  ram_data_i,
  output logic                      s2_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [1:0]           status_o,
  output logic      [31:0]          alloc_addr_o,
  output logic      [2:0]           pool_o,
  output logic      [6:0]           cnt_o
);

  localparam int AW = ADDR_BITS;
  localparam int PW = IDX_BITS + BYTES_W;

  fbpa_stage_t          s2_q;
  logic [2:0]           s2_pool_q;
  logic [6:0]           s2_cnt_q;
  logic [AW-1:0]        s2_start_q;
  logic [BYTES_W-1:0]   s2_bytes_q;
  logic [IDX_BITS-1:0]  s2_idx_q;

  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [31:0]          out_addr_q;
  logic [2:0]           out_pool_q;
  logic [6:0]           out_cnt_q;

  logic                 out_en;
  logic [IDX_BITS-1:0]  idx_sel;
  logic [PW-1:0]        offset;
  logic [AW-1:0]        addr_sum;
  logic [63:0]          addr_wide;

  assign out_en     = ~out_valid_q | out_ready_i;
  assign s2_ready_o = ~s2_q.valid | out_en;

  assign idx_sel   = s2_q.use_ram ? ram_data_i : s2_idx_q;
  assign offset    = PW'(idx_sel) * PW'(s2_bytes_q);
  assign addr_sum  = s2_start_q + AW'(offset);
  assign addr_wide = 64'(addr_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready_o) begin
        s2_q <= stage_i;
      end
      if (out_en) begin
        out_valid_q <= s2_q.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready_o && stage_i.valid) begin
      s2_pool_q  <= pool_i;
      s2_cnt_q   <= cnt_i;
      s2_start_q <= start_i;
      s2_bytes_q <= bytes_i;
      s2_idx_q   <= idx_i;
    end
    if (out_en && s2_q.valid) begin
      out_status_q <= s2_q.status;
      out_addr_q   <= s2_q.alloc_ok ? addr_wide[31:0] : 32'd0;
      out_pool_q   <= s2_pool_q;
      out_cnt_q    <= s2_cnt_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign alloc_addr_o = out_addr_q;
  assign pool_o       = out_pool_q;
  assign cnt_o        = out_cnt_q;

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator_unit.sv
// Fixed block pool allocator top level: APB registers, pool stage, stack RAM,
// result stage. Depends on fbpa_pkg, fbpa_apb_regs, fbpa_pool_state,
// fbpa_ram and fbpa_result.
//
// Usage:
//   Requests enter on the s_axis channel (tuser = request type, tdata = size
//   and block address); one result per request leaves on m_axis (tuser =
//   status, tdata = address, pool and free count). The user is to write heap_base
//   and heap_end over APB while the block is idle (the block does not enforce
//   this); an init request then lays out the pools.
//   Allocate and free: one item per cycle while m_axis_tready is high; an
//   accepted request passes the input, result stage and output registers. The
//   pool stage reads and updates the selected pool's stack top in the same
//   cycle; the stack RAM read lands in the result stage. Init: the layout
//   sequencer handles one pool per cycle, the last waiting for a ready result
//   stage, so an init holds the input stage until every pool is laid out.
//   Reset: all pools empty and unlaid, registers zero. The stack RAM needs no
//   clearing pass; each pool tracks its lowest fill since layout and entries
//   below it are taken as their own index.
//   When m_axis_tready is low the output register holds its item; up to two
//   further items are buffered in the pipeline before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int POOL_COUNT = 7,
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // req_size[15:0], block_addr[47:16]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // alloc_addr[31:0], pool_index[34:32],
                                           // pool_free_count[41:35], zero[47:42]
  output logic      [1:0]  m_axis_tuser,   // status[1:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW  = ADDR_BITS;
  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int RAW = (POOL_COUNT * MAX_BLOCKS > 1) ? $clog2(POOL_COUNT * MAX_BLOCKS) : 1;

  logic [31:0]        heap_base;
  logic [31:0]        heap_end;
  logic [63:0]        base_wide;
  logic [63:0]        end_wide;
  logic [63:0]        req_addr_wide;

  fbpa_stage_t        stage;
  logic [2:0]         st_pool;
  logic [6:0]         st_cnt;
  logic [AW-1:0]      st_start;
  logic [BYTES_W-1:0] st_bytes;
  logic [IW-1:0]      st_idx;
  logic               s2_ready;

  logic               ram_we;
  logic [RAW-1:0]     ram_waddr;
  logic [IW-1:0]      ram_wdata;
  logic               ram_re;
  logic [RAW-1:0]     ram_raddr;
  logic [IW-1:0]      ram_rdata;

  logic [1:0]         res_status;
  logic [31:0]        res_addr;
  logic [2:0]         res_pool;
  logic [6:0]         res_cnt;

  assign base_wide     = 64'(heap_base);
  assign end_wide      = 64'(heap_end);
  assign req_addr_wide = 64'(s_axis_tdata[47:16]);

  fbpa_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .heap_base_o (heap_base),
    .heap_end_o  (heap_end)
  );

  fbpa_pool_state #(
    .POOL_COUNT (POOL_COUNT),
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .req_size_i  (s_axis_tdata[15:0]),
    .req_addr_i  (req_addr_wide[AW-1:0]),
    .heap_base_i (base_wide[AW-1:0]),
    .heap_end_i  (end_wide[AW-1:0]),
    .s2_ready_i  (s2_ready),
    .stage_o     (stage),
    .pool_o      (st_pool),
    .cnt_o       (st_cnt),
    .start_o     (st_start),
    .bytes_o     (st_bytes),
    .idx_o       (st_idx),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  fbpa_ram #(
    .WIDTH (IW),
    .DEPTH (POOL_COUNT * MAX_BLOCKS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fbpa_result #(
    .ADDR_BITS (ADDR_BITS),
    .IDX_BITS  (IW)
  ) u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .pool_i       (st_pool),
    .cnt_i        (st_cnt),
    .start_i      (st_start),
    .bytes_i      (st_bytes),
    .idx_i        (st_idx),
    .ram_data_i   (ram_rdata),
    .s2_ready_o   (s2_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (res_status),
    .alloc_addr_o (res_addr),
    .pool_o       (res_pool),
    .cnt_o        (res_cnt)
  );

  assign m_axis_tdata = {6'd0, res_cnt, res_pool, res_addr};
  assign m_axis_tuser = res_status;

endmodule

`default_nettype wire

FILE: rtl/fbpa_checker.sv
// Port-level checker for the allocator result channel, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_checker import fbpa_pkg::*; #(
  parameter int POOL_COUNT = 7
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_no_mem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NO_MEM) |-> (m_axis_tdata[41:0] == '0))
    else $error("out of memory item carries nonzero fields");

  a_below_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_BELOW_HEAP) |-> (m_axis_tdata[41:0] == '0))
    else $error("below heap item carries nonzero fields");

  a_reject_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_REJECTED) |-> (m_axis_tdata[31:0] == '0))
    else $error("rejected free returns an address");

  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34:32] <= 3'(POOL_COUNT - 1)))
    else $error("pool index out of range");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker #(
  .POOL_COUNT (POOL_COUNT)
) u_fbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/fbpa_reply_checker.sv
// Reply checker for the fixed block pool allocator: watches the request, reply and APB
// channels, keeps its own pool/free-stack state and compares every reply in order.
// Depends on fbpa_pkg for the request and status codes.
`timescale 1ns / 1ps

module fbpa_reply_checker import fbpa_pkg::*; #(
  parameter logic [2:0] BASE_REG = 3'd0,
  parameter logic [2:0] END_REG  = 3'd4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // req_size[15:0], block_addr[47:16]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // alloc_addr[31:0], pool_index[34:32],
                                      // pool_free_count[41:35], zero[47:42]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches_o,
  output int          backlog_o
);

  localparam int POOLS = 7;
  localparam int DEPTH = 64;
  localparam int BLK_BYTES [POOLS] = '{8, 16, 32, 48, 64, 128, 256};
  localparam int BLK_COUNT [POOLS] = '{40, 20, 20, 20, 20, 10, 5};

  typedef struct packed {
    status_e     status;
    logic [5:0]  pad;
    logic [6:0]  left;
    logic [2:0]  pool;
    logic [31:0] addr;
  } reply_t;

  logic [31:0] heap_lo;
  logic [31:0] heap_hi;
  logic [31:0] start_addr [POOLS];
  int          laid [POOLS];
  int          avail [POOLS];
  logic [5:0]  stack_mem [POOLS][DEPTH];
  reply_t      due_replies [$];
  int          mismatches;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic string fmt_reply(input reply_t r);
    return $sformatf("status=%0d addr=%h pool=%0d left=%0d pad=%h",
                     r.status, r.addr, r.pool, r.left, r.pad);
  endfunction

  // one request against the pool state; returns the reply it must produce
  function automatic reply_t pool_step(input logic [1:0] kind, input logic [15:0] size,
                                       input logic [31:0] addr);
    reply_t      r;
    longint      ptr;
    longint      lim;
    longint      idx;
    logic [31:0] offs;
    int          p;
    r = '0;
    case (kind)
      REQ_INIT: begin
        ptr = longint'(heap_lo);
        lim = longint'(heap_hi);
        for (p = 0; p < POOLS; p++) begin
          start_addr[p] = ptr[31:0];
          laid[p] = 0;
          avail[p] = 0;
          for (int b = 0; b < BLK_COUNT[p] && b < DEPTH; b++) begin
            if (lim < BLK_BYTES[p] || ptr >= lim - BLK_BYTES[p]) break;
            stack_mem[p][b] = 6'(b);
            laid[p] = b + 1;
            avail[p] = b + 1;
            ptr = ptr + BLK_BYTES[p];
          end
        end
      end
      REQ_ALLOC: begin
        r.status = ST_NO_MEM;
        for (p = 0; p < POOLS; p++) begin
          if (BLK_BYTES[p] >= int'(size) && avail[p] > 0) begin
            avail[p]--;
            r.status = ST_OK;
            r.addr = start_addr[p] + 32'(stack_mem[p][avail[p]]) * 32'(BLK_BYTES[p]);
            r.pool = 3'(p);
            r.left = 7'(avail[p]);
            break;
          end
        end
      end
      REQ_FREE: begin
        p = POOLS - 1;
        while (p >= 0 && addr < start_addr[p]) p--;
        if (p < 0) begin
          r.status = ST_BELOW_HEAP;
        end else begin
          offs = addr - start_addr[p];
          idx = longint'(offs) / BLK_BYTES[p];
          r.pool = 3'(p);
          if (idx >= laid[p] || avail[p] >= laid[p]) begin
            r.status = ST_REJECTED;
          end else begin
            stack_mem[p][avail[p]] = 6'(idx);
            avail[p]++;
          end
          r.left = 7'(avail[p]);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    reply_t seen;
    reply_t want;
    if (!rst_ni) begin
      heap_lo = '0;
      heap_hi = '0;
      for (int p = 0; p < POOLS; p++) begin
        start_addr[p] = '0;
        laid[p] = 0;
        avail[p] = 0;
      end
      due_replies.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == BASE_REG) heap_lo = pwdata;
          else if (paddr == END_REG) heap_hi = pwdata;
        end else if (paddr == BASE_REG && prdata !== heap_lo) begin
          report_mismatch($sformatf("heap_base read %h, expected %h", prdata, heap_lo));
        end else if (paddr == END_REG && prdata !== heap_hi) begin
          report_mismatch($sformatf("heap_end read %h, expected %h", prdata, heap_hi));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tuser, m_axis_tdata};
        if (due_replies.size() == 0) begin
          report_mismatch({"reply with none pending: ", fmt_reply(seen)});
        end else begin
          want = due_replies.pop_front();
          if (seen !== want)
            report_mismatch({"got ", fmt_reply(seen), " expected ", fmt_reply(want)});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_replies.push_back(pool_step(s_axis_tuser, s_axis_tdata[15:0],
                                        s_axis_tdata[47:16]));
    end
    backlog_o <= due_replies.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for fixed_block_pool_allocator_unit: clock, reset, APB setup, directed and
// random request streams with idle phases, watchdog and verdict.
// Depends on fbpa_pkg, the block RTL and fbpa_reply_checker.
`timescale 1ns / 1ps

module tb_top;
  import fbpa_pkg::*;

  localparam logic [2:0] REG_HEAP_BASE = 3'd0;
  localparam logic [2:0] REG_HEAP_END  = 3'd4;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int RANDOM_ITEMS = 1080;
  localparam int PHASES       = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int POOL_SPAN    = 6080;
  localparam logic [15:0] DIRECTED_SIZES [14] =
    '{16'd0, 16'd1, 16'd8, 16'd16, 16'd33, 16'd48, 16'd49, 16'd64, 16'd65,
      16'd128, 16'd129, 16'd256, 16'd257, 16'd65535};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [1:0]  m_user;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          backlog;

  int          send_pct = 0;
  int          recv_pct = 0;
  int          quiet = 0;
  logic [31:0] cur_base = '0;
  logic [31:0] live_blocks [$];
  int          kind_sent [4] = '{0, 0, 0, 0};
  int          allocs_ok = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fixed_block_pool_allocator_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  fbpa_reply_checker #(
    .BASE_REG (REG_HEAP_BASE),
    .END_REG  (REG_HEAP_END)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .backlog_o     (backlog)
  );

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_pct);
  end

  // granted blocks are recycled as free requests
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready && m_user == ST_OK && m_data[31:0] != '0) begin
      live_blocks.push_back(m_data[31:0]);
      allocs_ok++;
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !rst_n) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("fixed_block_pool_allocator_unit test failed");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap(input logic [31:0] lo, input logic [31:0] hi);
    apb_access(1'b1, REG_HEAP_BASE, lo);
    apb_access(1'b1, REG_HEAP_END, hi);
    apb_access(1'b0, REG_HEAP_BASE, '0);
    apb_access(1'b0, REG_HEAP_END, '0);
    cur_base = lo;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [15:0] size,
                          input logic [31:0] addr);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {addr, size};
    do @(posedge clk); while (!s_ready);
    kind_sent[kind]++;
  endtask

  task automatic random_item();
    int          pick;
    int          k;
    logic [15:0] sz;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick >= 40 && pick < 75 && live_blocks.size() == 0) pick = 0;
    if (pick < 40) begin
      k = $urandom_range(99);
      if (k < 80) sz = 16'($urandom_range(256, 1));
      else if (k < 88) sz = '0;
      else if (k < 95) sz = 16'($urandom_range(65535, 257));
      else sz = 16'($urandom);
      send_req(REQ_ALLOC, sz, $urandom);
    end else if (pick < 75) begin
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k] + $urandom_range(7);
      // keep some entries so the same block gets freed twice
      if ($urandom_range(9) != 0) live_blocks.delete(k);
      send_req(REQ_FREE, 16'($urandom), a);
    end else if (pick < 87) begin
      send_req(REQ_FREE, 16'($urandom), cur_base + $urandom_range(POOL_SPAN + 200));
    end else if (pick < 94) begin
      send_req(REQ_FREE, 16'($urandom), $urandom);
    end else if (pick < 97) begin
      send_req(REQ_UNUSED, 16'($urandom), $urandom);
    end else begin
      live_blocks.delete();
      send_req(REQ_INIT, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any layout: everything empty
    send_req(REQ_ALLOC, 16'd8, '0);
    send_req(REQ_FREE, '0, 32'h0000_0100);
    send_req(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(REQ_INIT, '0, '0);
    drain();

    set_heap(32'h0000_1000, 32'h0000_3000);
    send_req(REQ_INIT, '0, '0);
    foreach (DIRECTED_SIZES[i]) send_req(REQ_ALLOC, DIRECTED_SIZES[i], '0);
    send_req(REQ_FREE, '0, 32'h0000_0FFF);   // below heap
    send_req(REQ_FREE, '0, 32'h0000_1003);
    send_req(REQ_FREE, '0, 32'h0000_2FFC);   // past the laid blocks of the last pool
    send_req(REQ_FREE, '0, 32'h0000_22C0);
    send_req(REQ_FREE, '0, 32'h0000_22C5);
    send_req(REQ_FREE, '0, 32'h0000_2342);   // stack already full
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      live_blocks.delete();
      send_pct = 0;
      recv_pct = 0;
      case (ph)
        0: begin lo = 32'h0000_1000; hi = 32'h0000_3000; end
        1: begin lo = 32'h0000_0000; hi = 32'hFFFF_FFFF; end
        2: begin lo = 32'h0000_4000; hi = lo + $urandom_range(3000, 100); end
        3: begin lo = 32'hFFFF_E000; hi = 32'hFFFF_FFFF; end
        4: begin lo = $urandom_range(32'h7FFF_0000); hi = lo + $urandom_range(7000); end
        5: begin lo = 32'hFFFF_FFFF; hi = 32'h0000_0000; end
        6: begin lo = 32'h0000_2000; hi = 32'h0000_0100; end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      set_heap(lo, hi);
      send_pct = (ph % 4 == 1) ? 56 : (ph % 4 == 3) ? 7 : 0;
      recv_pct = (ph % 4 == 2) ? 56 : (ph % 4 == 3) ? 7 : 0;
      send_req(REQ_INIT, 16'($urandom), $urandom);
      repeat (RANDOM_ITEMS / PHASES) random_item();
    end

    drain();
    repeat (16) @(posedge clk);
    $display("requests: %0d init, %0d alloc (%0d granted), %0d free, %0d unknown type",
             kind_sent[REQ_INIT], kind_sent[REQ_ALLOC], allocs_ok, kind_sent[REQ_FREE],
             kind_sent[REQ_UNUSED]);
    $display("%0d heap layouts incl. empty, inverted and top-of-range; %0d mismatches",
             PHASES + 2, mismatches);
    if (mismatches == 0) begin
      $display("fixed_block_pool_allocator_unit test passed");
    end else begin
      $display("fixed_block_pool_allocator_unit test failed");
    end
    $finish;
  end

endmodule
